// ===== sv/uvs_pkg.sv =====
`default_nettype none
package uvs_pkg;

   localparam int CNT_W        = 7;
   localparam int IDX_W        = 7;
   localparam int OUT_W        = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int PHASE_W      = 32;
   localparam int TRIG_W       = 32;
   localparam int CORDIC_W     = 34;

   localparam logic [CNT_W-1:0] MAX_SECTORS = 7'd64;
   localparam logic [CNT_W-1:0] MAX_STACKS  = 7'd64;
   localparam logic [CNT_W-1:0] SECTOR_RESET = 7'd9;
   localparam logic [CNT_W-1:0] STACK_RESET  = 7'd8;

   localparam logic [CSR_INDEX_W-1:0] CSR_SECTOR_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STACK_COUNT  = 2'd1;

   localparam int DIV_STEPS    = 32;
   localparam int TEX_STEP     = 15;
   localparam int THETA_STEP   = 31;
   localparam int CORDIC_STEPS = 24;
   localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
   // input, divider steps, rounding, cordic, multiply
   localparam int PIPE_LEN     = 1 + DIV_STEPS + 1 + CORDIC_LAT + 1;

   localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;

   typedef struct packed {
      logic [OUT_W-1:0] tex_s;
      logic [OUT_W-1:0] tex_t;
      logic             err;
   } side_type;

   function automatic logic [PHASE_W-1:0] atan_turn(input int k);
      logic [PHASE_W-1:0] a;
      case (k)
         0:  a = 32'd536870912;
         1:  a = 32'd316933406;
         2:  a = 32'd167458907;
         3:  a = 32'd85004756;
         4:  a = 32'd42667331;
         5:  a = 32'd21354465;
         6:  a = 32'd10679838;
         7:  a = 32'd5340245;
         8:  a = 32'd2670163;
         9:  a = 32'd1335087;
         10: a = 32'd667544;
         11: a = 32'd333772;
         12: a = 32'd166886;
         13: a = 32'd83443;
         14: a = 32'd41721;
         15: a = 32'd20860;
         16: a = 32'd10430;
         17: a = 32'd5215;
         18: a = 32'd2607;
         19: a = 32'd1303;
         20: a = 32'd651;
         21: a = 32'd325;
         22: a = 32'd162;
         23: a = 32'd81;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

// ===== sv/uv_sphere_vertex_generator.sv =====
// Pipeline: integer divider step, 32 one-bit divider steps, rounding,
// a 24-step CORDIC pair, a multiply stage and the output registers.
// Throughput: one item per cycle while the result side does not stall.
// A stall on the result side holds the whole pipeline in place.
// Reset (synchronous): pipeline empty, sector_count 9, stack_count 8.
`default_nettype none
module uv_sphere_vertex_generator (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [uvs_pkg::IDX_W-1:0]          req_stack_index,
   input  wire logic [uvs_pkg::IDX_W-1:0]          req_sector_index,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [uvs_pkg::OUT_W-1:0]        rsp_pos_x,
   output logic signed [uvs_pkg::OUT_W-1:0]        rsp_pos_y,
   output logic signed [uvs_pkg::OUT_W-1:0]        rsp_pos_z,
   output logic [uvs_pkg::OUT_W-1:0]               rsp_tex_s,
   output logic [uvs_pkg::OUT_W-1:0]               rsp_tex_t,
   output logic                                    rsp_index_error,
   input  wire logic                               csr_write_enable,
   input  wire logic [uvs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [uvs_pkg::CNT_W-1:0]          csr_write_data
);
   import uvs_pkg::*;

   typedef struct packed {
      logic                  err;
      logic [CNT_W-1:0]      i_rem;
      logic [CNT_W-1:0]      j_rem;
      logic [PHASE_W:0]      i_quo;
      logic [PHASE_W:0]      j_quo;
      logic [OUT_W-1:0]      s_quo;
      logic [CNT_W-1:0]      s_rem;
      logic [OUT_W-1:0]      t_quo;
      logic [CNT_W-1:0]      t_rem;
      logic [PHASE_W-1:0]    p_quo;
      logic [CNT_W-1:0]      p_rem;
   } div_type;

   typedef struct packed {
      logic [PHASE_W-1:0] theta;
      logic [PHASE_W-1:0] phi;
      side_type           side;
   } rnd_type;

   function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c,
                                                    input logic [CNT_W-1:0] mx);
      logic [CNT_W-1:0] r;
      if (c == '0)
         r = 7'd1;
      else if (c > mx)
         r = mx;
      else
         r = c;
      return r;
   endfunction

   function automatic logic [CNT_W:0] div_step(input logic [CNT_W-1:0] r,
                                               input logic [CNT_W-1:0] d);
      logic [CNT_W:0] r2;
      logic [CNT_W:0] diff;
      r2   = {r, 1'b0};
      diff = r2 - {1'b0, d};
      if (r2 >= {1'b0, d})
         return {1'b1, diff[CNT_W-1:0]};
      else
         return {1'b0, r2[CNT_W-1:0]};
   endfunction

   function automatic logic [OUT_W-1:0] sat16(input logic signed [63:0] v);
      logic [OUT_W-1:0] r;
      if (v > 64'sd32767)
         r = 16'h7FFF;
      else if (v < -64'sd32768)
         r = 16'h8000;
      else
         r = v[OUT_W-1:0];
      return r;
   endfunction

   logic [CNT_W-1:0]       sectors_ff, stacks_ff;
   logic [PIPE_LEN-1:0]    v_ff;
   logic                   rsp_valid_ff;
   logic                   pipe_en;

   div_type                div_ff [0:DIV_STEPS];
   div_type                div_in [0:DIV_STEPS];
   rnd_type                rnd_ff, rnd_in;
   side_type               side_ff [0:CORDIC_LAT-1];

   logic signed [TRIG_W-1:0] cos_t, sin_t, cos_p, sin_p;
   logic signed [63:0]     prod_x_ff, prod_y_ff, prod_x_in, prod_y_in;
   logic signed [TRIG_W-1:0] ct_ff;
   side_type               side2_ff;

   logic [OUT_W-1:0]       pos_x_ff, pos_y_ff, pos_z_ff, tex_s_ff, tex_t_ff;
   logic [OUT_W-1:0]       pos_x_in, pos_y_in, pos_z_in, tex_s_in, tex_t_in;
   logic                   err_ff, err_in;

   assign pipe_en   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !pipe_en;

   // config
   always_ff @(posedge clock) begin
      if (reset) begin
         sectors_ff <= SECTOR_RESET;
         stacks_ff  <= STACK_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SECTOR_COUNT: sectors_ff <= clamp_count(csr_write_data, MAX_SECTORS);
            CSR_STACK_COUNT:  stacks_ff  <= clamp_count(csr_write_data, MAX_STACKS);
            default: ;
         endcase
      end
   end

   // divider: integer part first, then one quotient bit per stage
   always_comb begin
      logic       i_ge, j_ge;
      logic [CNT_W:0] si, sj;
      i_ge = req_stack_index >= stacks_ff;
      j_ge = req_sector_index >= sectors_ff;
      div_in[0]       = '0;
      div_in[0].err   = (req_stack_index > stacks_ff) || (req_sector_index > sectors_ff);
      div_in[0].i_rem = i_ge ? req_stack_index - stacks_ff : req_stack_index;
      div_in[0].j_rem = j_ge ? req_sector_index - sectors_ff : req_sector_index;
      div_in[0].i_quo = {{PHASE_W{1'b0}}, i_ge};
      div_in[0].j_quo = {{PHASE_W{1'b0}}, j_ge};
      for (int k = 1; k <= DIV_STEPS; k++) begin
         div_in[k] = div_ff[k-1];
         si = div_step(div_ff[k-1].i_rem, stacks_ff);
         sj = div_step(div_ff[k-1].j_rem, sectors_ff);
         div_in[k].i_rem = si[CNT_W-1:0];
         div_in[k].j_rem = sj[CNT_W-1:0];
         div_in[k].i_quo = {div_ff[k-1].i_quo[PHASE_W-1:0], si[CNT_W]};
         div_in[k].j_quo = {div_ff[k-1].j_quo[PHASE_W-1:0], sj[CNT_W]};
         if (k == TEX_STEP) begin
            div_in[k].t_quo = div_in[k].i_quo[OUT_W-1:0];
            div_in[k].t_rem = si[CNT_W-1:0];
            div_in[k].s_quo = div_in[k].j_quo[OUT_W-1:0];
            div_in[k].s_rem = sj[CNT_W-1:0];
         end
         if (k == THETA_STEP) begin
            div_in[k].p_quo = div_in[k].i_quo[PHASE_W-1:0];
            div_in[k].p_rem = si[CNT_W-1:0];
         end
      end
   end

   // round half up: remainder at or above ceil(d/2)
   always_comb begin
      logic [CNT_W:0] hm, hn;
      logic       up_m, up_n, up_s, up_t;
      hm = ({1'b0, sectors_ff} + 8'd1) >> 1;
      hn = ({1'b0, stacks_ff} + 8'd1) >> 1;
      up_m = {1'b0, div_ff[DIV_STEPS].j_rem} >= hm;
      up_n = {1'b0, div_ff[DIV_STEPS].p_rem} >= hn;
      up_s = {1'b0, div_ff[DIV_STEPS].s_rem} >= hm;
      up_t = {1'b0, div_ff[DIV_STEPS].t_rem} >= hn;
      rnd_in.phi        = div_ff[DIV_STEPS].j_quo[PHASE_W-1:0] + {31'b0, up_m};
      rnd_in.theta      = div_ff[DIV_STEPS].p_quo + {31'b0, up_n};
      rnd_in.side.tex_s = div_ff[DIV_STEPS].s_quo + {15'b0, up_s};
      rnd_in.side.tex_t = div_ff[DIV_STEPS].t_quo + {15'b0, up_t};
      rnd_in.side.err   = div_ff[DIV_STEPS].err;
   end

   uvs_cordic u_cordic_theta (
      .clock   (clock),
      .enable  (pipe_en),
      .phase   (rnd_ff.theta),
      .cos_out (cos_t),
      .sin_out (sin_t)
   );

   uvs_cordic u_cordic_phi (
      .clock   (clock),
      .enable  (pipe_en),
      .phase   (rnd_ff.phi),
      .cos_out (cos_p),
      .sin_out (sin_p)
   );

   assign prod_x_in = sin_t * cos_p;
   assign prod_y_in = sin_t * sin_p;

   always_comb begin
      logic signed [63:0] zs;
      zs = ($signed({{(64-TRIG_W){ct_ff[TRIG_W-1]}}, ct_ff}) + 64'sd16384) >>> 15;
      pos_x_in = sat16((prod_x_ff + (64'sd1 <<< 44)) >>> 45);
      pos_y_in = sat16((prod_y_ff + (64'sd1 <<< 44)) >>> 45);
      pos_z_in = sat16(zs);
      tex_s_in = side2_ff.tex_s;
      tex_t_in = side2_ff.tex_t;
      err_in   = side2_ff.err;
      if (side2_ff.err) begin
         pos_x_in = '0;
         pos_y_in = '0;
         pos_z_in = '0;
         tex_s_in = '0;
         tex_t_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         v_ff         <= {v_ff[PIPE_LEN-2:0], req_valid};
         rsp_valid_ff <= v_ff[PIPE_LEN-1];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int k = 0; k <= DIV_STEPS; k++)
            div_ff[k] <= div_in[k];
         rnd_ff     <= rnd_in;
         side_ff[0] <= rnd_ff.side;
         for (int k = 1; k < CORDIC_LAT; k++)
            side_ff[k] <= side_ff[k-1];
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         ct_ff     <= cos_t;
         side2_ff  <= side_ff[CORDIC_LAT-1];
         pos_x_ff  <= pos_x_in;
         pos_y_ff  <= pos_y_in;
         pos_z_ff  <= pos_z_in;
         tex_s_ff  <= tex_s_in;
         tex_t_ff  <= tex_t_in;
         err_ff    <= err_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = $signed(pos_x_ff);
   assign rsp_pos_y       = $signed(pos_y_ff);
   assign rsp_pos_z       = $signed(pos_z_ff);
   assign rsp_tex_s       = tex_s_ff;
   assign rsp_tex_t       = tex_t_ff;
   assign rsp_index_error = err_ff;

endmodule
`default_nettype wire

// ===== sv/uvs_cordic.sv =====
`default_nettype none
module uvs_cordic (
   input  wire logic                                  clock,
   input  wire logic                                  enable,
   input  wire logic [uvs_pkg::PHASE_W-1:0]           phase,
   output logic signed [uvs_pkg::TRIG_W-1:0]          cos_out,
   output logic signed [uvs_pkg::TRIG_W-1:0]          sin_out
);
   import uvs_pkg::*;

   logic signed [CORDIC_W-1:0] x_ff [0:CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] y_ff [0:CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] z_ff [0:CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] x_in [0:CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] y_in [0:CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] z_in [0:CORDIC_STEPS];
   logic [CORDIC_STEPS:0]      flip_ff;
   logic [CORDIC_STEPS:0]      flip_in;
   logic signed [TRIG_W-1:0]   cos_ff, sin_ff;
   logic signed [TRIG_W-1:0]   cos_in, sin_in;

   always_comb begin
      logic [PHASE_W-1:0] ph_sum;
      logic [PHASE_W-1:0] red;
      logic signed [CORDIC_W-1:0] ang;
      ph_sum = phase + 32'h4000_0000;
      flip_in[0] = ph_sum[PHASE_W-1];
      red = phase ^ {flip_in[0], {(PHASE_W-1){1'b0}}};
      x_in[0] = CORDIC_X0;
      y_in[0] = '0;
      z_in[0] = $signed({{(CORDIC_W-PHASE_W){red[PHASE_W-1]}}, red});
      for (int k = 0; k < CORDIC_STEPS; k++) begin
         ang = $signed({{(CORDIC_W-PHASE_W){1'b0}}, atan_turn(k)});
         flip_in[k+1] = flip_ff[k];
         if (z_ff[k] >= 0) begin
            x_in[k+1] = x_ff[k] - (y_ff[k] >>> k);
            y_in[k+1] = y_ff[k] + (x_ff[k] >>> k);
            z_in[k+1] = z_ff[k] - ang;
         end else begin
            x_in[k+1] = x_ff[k] + (y_ff[k] >>> k);
            y_in[k+1] = y_ff[k] - (x_ff[k] >>> k);
            z_in[k+1] = z_ff[k] + ang;
         end
      end
      if (flip_ff[CORDIC_STEPS]) begin
         cos_in = TRIG_W'(-x_ff[CORDIC_STEPS]);
         sin_in = TRIG_W'(-y_ff[CORDIC_STEPS]);
      end else begin
         cos_in = TRIG_W'(x_ff[CORDIC_STEPS]);
         sin_in = TRIG_W'(y_ff[CORDIC_STEPS]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k <= CORDIC_STEPS; k++) begin
            x_ff[k] <= x_in[k];
            y_ff[k] <= y_in[k];
            z_ff[k] <= z_in[k];
         end
         flip_ff <= flip_in;
         cos_ff  <= cos_in;
         sin_ff  <= sin_in;
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule
`default_nettype wire
